/* rtl/core/rnta_pkg.sv */
// Package for the radix number to ASCII core: widths, codes, sequencer states
// and the control structs shared by the divider, digit stack and top level.
// No dependencies.
`default_nettype none

package rnta_pkg;

   localparam int VALUE_WIDTH = 32;
   localparam int RADIX_W     = 6;
   localparam int DIGIT_W     = 6;
   localparam int CHAR_W      = 7;
   localparam int STACK_DEPTH = VALUE_WIDTH;
   localparam int CNT_W       = $clog2(STACK_DEPTH + 1);
   localparam int IDX_W       = $clog2(STACK_DEPTH);
   localparam int STEP_W      = $clog2(VALUE_WIDTH);

   localparam logic [CHAR_W-1:0]  DIGIT_BASE_CHAR  = 7'd48;
   localparam logic [CHAR_W-1:0]  LETTER_BASE_CHAR = 7'd87;
   localparam logic [CHAR_W-1:0]  SPACE_CHAR       = 7'd32;
   localparam logic [CHAR_W-1:0]  ERROR_CHAR       = 7'd0;
   localparam logic [DIGIT_W-1:0] DECIMAL_LIMIT    = 6'd10;
   localparam logic [RADIX_W-1:0] MIN_RADIX        = 6'd2;
   localparam logic [RADIX_W-1:0] MAX_RADIX        = 6'd36;
   localparam logic [RADIX_W-1:0] HEX_RADIX        = 6'd16;
   localparam logic [RADIX_W-1:0] OCT_RADIX        = 6'd8;
   localparam logic [RADIX_W-1:0] BIN_RADIX        = 6'd2;

   typedef logic [VALUE_WIDTH-1:0] value_type;
   typedef logic [RADIX_W-1:0]     radix_type;
   typedef logic [DIGIT_W-1:0]     digit_type;
   typedef logic [CHAR_W-1:0]      char_type;
   typedef logic [CNT_W-1:0]       count_type;

   typedef enum logic [1:0] {
      OP_HEX   = 2'd0,
      OP_OCT   = 2'd1,
      OP_BIN   = 2'd2,
      OP_GIVEN = 2'd3
   } opcode_type;

   typedef enum logic [2:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_EMIT,
      ST_SPACE,
      ST_ERROR
   } state_type;

   typedef struct packed {
      logic      start;
      value_type dividend;
      radix_type divisor;
   } div_ctl_type;

   typedef struct packed {
      logic      done;
      value_type quotient;
      digit_type remainder;
   } div_sts_type;

   typedef struct packed {
      logic      push;
      logic      pop;
      digit_type digit;
   } stk_ctl_type;

   typedef struct packed {
      count_type count;
      digit_type top;
   } stk_sts_type;

   function automatic char_type digit_to_char(input digit_type d);
      char_type c;
      if (d < DECIMAL_LIMIT) begin
         c = DIGIT_BASE_CHAR + CHAR_W'(d);
      end else begin
         c = LETTER_BASE_CHAR + CHAR_W'(d);
      end
      return c;
   endfunction

endpackage

`default_nettype wire

/* rtl/core/rnta_divider.sv */
// Iterative restoring divider: one quotient bit per cycle into a VALUE_WIDTH-bit
// quotient. Depends on rnta_pkg.
`default_nettype none

module rnta_divider (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rnta_pkg::div_ctl_type ctl,
   output      rnta_pkg::div_sts_type sts
);

   rnta_pkg::value_type            quo_ff, quo_in;
   rnta_pkg::digit_type            rem_ff, rem_in;
   rnta_pkg::radix_type            div_ff, div_in;
   logic [rnta_pkg::STEP_W-1:0]    step_ff, step_in;
   logic                           run_ff, run_in;
   logic                           done_ff, done_in;

   logic [rnta_pkg::DIGIT_W:0]     trial;
   logic [rnta_pkg::DIGIT_W:0]     diff;
   logic                           fits;

   always_comb begin
      trial = {rem_ff, quo_ff[rnta_pkg::VALUE_WIDTH-1]};
      diff  = trial - {1'b0, div_ff};
      fits  = (trial >= {1'b0, div_ff});

      quo_in  = quo_ff;
      rem_in  = rem_ff;
      div_in  = div_ff;
      step_in = step_ff;
      run_in  = run_ff;
      done_in = 1'b0;

      if (ctl.start) begin
         quo_in  = ctl.dividend;
         rem_in  = '0;
         div_in  = ctl.divisor;
         step_in = '0;
         run_in  = 1'b1;
      end else if (run_ff) begin
         // shift in the next dividend bit, subtract when the divisor fits
         quo_in = {quo_ff[rnta_pkg::VALUE_WIDTH-2:0], fits};
         rem_in = fits ? diff[rnta_pkg::DIGIT_W-1:0] : trial[rnta_pkg::DIGIT_W-1:0];
         if (step_ff == rnta_pkg::STEP_W'(rnta_pkg::VALUE_WIDTH - 1)) begin
            run_in  = 1'b0;
            done_in = 1'b1;
         end else begin
            step_in = step_ff + 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         run_ff  <= 1'b0;
         done_ff <= 1'b0;
         step_ff <= '0;
      end else begin
         run_ff  <= run_in;
         done_ff <= done_in;
         step_ff <= step_in;
      end
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      div_ff <= div_in;
   end

   assign sts.done      = done_ff;
   assign sts.quotient  = quo_ff;
   assign sts.remainder = rem_ff;

endmodule

`default_nettype wire

/* rtl/core/rnta_digit_stack.sv */
// Digit stack: remainders pushed least significant first, popped most
// significant first. Depends on rnta_pkg.
`default_nettype none

module rnta_digit_stack (
   input  wire logic                 clock,
   input  wire logic                 reset,
   input  wire rnta_pkg::stk_ctl_type ctl,
   output      rnta_pkg::stk_sts_type sts
);

   rnta_pkg::digit_type digit_ff [rnta_pkg::STACK_DEPTH];
   rnta_pkg::count_type cnt_ff, cnt_in;
   rnta_pkg::count_type top_pos;

   always_comb begin
      top_pos = cnt_ff - rnta_pkg::CNT_W'(1);
      cnt_in  = cnt_ff;
      if (ctl.push) begin
         cnt_in = cnt_ff + rnta_pkg::CNT_W'(1);
      end else if (ctl.pop) begin
         cnt_in = top_pos;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cnt_ff <= '0;
      end else begin
         cnt_ff <= cnt_in;
      end
      if (ctl.push) begin
         digit_ff[cnt_ff[rnta_pkg::IDX_W-1:0]] <= ctl.digit;
      end
   end

   assign sts.count = cnt_ff;
   assign sts.top   = digit_ff[top_pos[rnta_pkg::IDX_W-1:0]];

endmodule

`default_nettype wire

/* rtl/core/radix_number_to_ascii_core.sv */
// Top level of the radix number to ASCII core: sequencer, output register,
// divider and digit stack. Depends on rnta_pkg, rnta_divider, rnta_digit_stack.
//
// Usage: a number enters on the req_ stream (opcode, radix, value) and leaves
// on the rsp_ stream as ASCII characters, most significant digit first, one
// transfer per character; rsp_tlast marks the final character of the number.
// Hex and octal output ends with a space. In given-base mode a radix below
// two yields a single transfer with char_code 0 and rsp_tuser (bad_base) set;
// radices above 36 are treated as 36. A zero value prints a single '0'.
// Operation: each digit costs one pass of the shared restoring divider, which
// produces one quotient bit per cycle. The digits are divided out and pushed
// on the digit stack least significant first; then the characters leave the
// output register one per cycle while the receiver is ready, followed by the
// space in hex and octal. A number has at most 32 digits, in binary. The next
// number can transfer once the last character is in the output register. A
// bad radix passes through the error state, which loads the error character,
// and then frees the input. req_tready is high only between numbers. rsp_ is
// driven from a register; when the receiver stalls, the character holds and
// the sequencer waits before loading the next one. Reset empties the digit
// stack, drops any pending character and returns to accepting input.
`default_nettype none

module radix_number_to_ascii_core (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_tvalid,
   output      logic        req_tready,
   input  wire logic [39:0] req_tdata,   // opcode [1:0], radix [7:2], value [39:8]
   output      logic        rsp_tvalid,
   input  wire logic        rsp_tready,
   output      logic [7:0]  rsp_tdata,   // char_code [6:0], zero [7]
   output      logic        rsp_tlast,
   output      logic        rsp_tuser    // bad_base [0]
);

   rnta_pkg::state_type   state_ff, state_in;
   rnta_pkg::radix_type   base_ff, base_in;
   logic                  space_ff, space_in;

   logic                  out_valid_ff, out_valid_in;
   rnta_pkg::char_type    out_char_ff, out_char_in;
   logic                  out_last_ff, out_last_in;
   logic                  out_bad_ff, out_bad_in;

   rnta_pkg::div_ctl_type div_ctl;
   rnta_pkg::div_sts_type div_sts;
   rnta_pkg::stk_ctl_type stk_ctl;
   rnta_pkg::stk_sts_type stk_sts;

   rnta_pkg::opcode_type  req_op;
   rnta_pkg::radix_type   req_radix;
   rnta_pkg::value_type   req_value;
   rnta_pkg::radix_type   dec_base;
   logic                  dec_space;
   logic                  dec_bad;
   logic                  out_free;
   logic                  req_take;

   rnta_divider u_divider (
      .clock (clock),
      .reset (reset),
      .ctl   (div_ctl),
      .sts   (div_sts)
   );

   rnta_digit_stack u_stack (
      .clock (clock),
      .reset (reset),
      .ctl   (stk_ctl),
      .sts   (stk_sts)
   );

   // decode the mode into a base
   always_comb begin
      req_op    = rnta_pkg::opcode_type'(req_tdata[1:0]);
      req_radix = req_tdata[7:2];
      req_value = rnta_pkg::value_type'(req_tdata[39:8]);
      dec_bad   = 1'b0;
      dec_space = 1'b0;
      dec_base  = rnta_pkg::BIN_RADIX;
      unique case (req_op)
         rnta_pkg::OP_HEX: begin
            dec_base  = rnta_pkg::HEX_RADIX;
            dec_space = 1'b1;
         end
         rnta_pkg::OP_OCT: begin
            dec_base  = rnta_pkg::OCT_RADIX;
            dec_space = 1'b1;
         end
         rnta_pkg::OP_BIN: begin
            dec_base = rnta_pkg::BIN_RADIX;
         end
         rnta_pkg::OP_GIVEN: begin
            dec_bad = (req_radix < rnta_pkg::MIN_RADIX);
            if (req_radix > rnta_pkg::MAX_RADIX) begin
               dec_base = rnta_pkg::MAX_RADIX;
            end else begin
               dec_base = req_radix;
            end
         end
      endcase
   end

   assign out_free   = !out_valid_ff || rsp_tready;
   assign req_tready = (state_ff == rnta_pkg::ST_IDLE);
   assign req_take   = req_tvalid && req_tready;

   always_comb begin
      state_in     = state_ff;
      base_in      = base_ff;
      space_in     = space_ff;
      out_valid_in = out_valid_ff && !rsp_tready;
      out_char_in  = out_char_ff;
      out_last_in  = out_last_ff;
      out_bad_in   = out_bad_ff;

      div_ctl.start    = 1'b0;
      div_ctl.dividend = div_sts.quotient;
      div_ctl.divisor  = base_ff;
      stk_ctl.push     = 1'b0;
      stk_ctl.pop      = 1'b0;
      stk_ctl.digit    = div_sts.remainder;

      unique case (state_ff)
         rnta_pkg::ST_IDLE: begin
            if (req_take) begin
               base_in  = dec_base;
               space_in = dec_space;
               if (dec_bad) begin
                  state_in = rnta_pkg::ST_ERROR;
               end else begin
                  div_ctl.start    = 1'b1;
                  div_ctl.dividend = req_value;
                  div_ctl.divisor  = dec_base;
                  state_in         = rnta_pkg::ST_DIVIDE;
               end
            end
         end
         rnta_pkg::ST_DIVIDE: begin
            if (div_sts.done) begin
               stk_ctl.push = 1'b1;
               if (div_sts.quotient == '0) begin
                  state_in = rnta_pkg::ST_EMIT;
               end else begin
                  div_ctl.start = 1'b1;
               end
            end
         end
         rnta_pkg::ST_EMIT: begin
            if (out_free) begin
               stk_ctl.pop  = 1'b1;
               out_valid_in = 1'b1;
               out_char_in  = rnta_pkg::digit_to_char(stk_sts.top);
               out_bad_in   = 1'b0;
               out_last_in  = (stk_sts.count == rnta_pkg::CNT_W'(1)) && !space_ff;
               if (stk_sts.count == rnta_pkg::CNT_W'(1)) begin
                  state_in = space_ff ? rnta_pkg::ST_SPACE : rnta_pkg::ST_IDLE;
               end
            end
         end
         rnta_pkg::ST_SPACE: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = rnta_pkg::SPACE_CHAR;
               out_last_in  = 1'b1;
               out_bad_in   = 1'b0;
               state_in     = rnta_pkg::ST_IDLE;
            end
         end
         rnta_pkg::ST_ERROR: begin
            if (out_free) begin
               out_valid_in = 1'b1;
               out_char_in  = rnta_pkg::ERROR_CHAR;
               out_last_in  = 1'b1;
               out_bad_in   = 1'b1;
               state_in     = rnta_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = rnta_pkg::ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= rnta_pkg::ST_IDLE;
         out_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         out_valid_ff <= out_valid_in;
      end
      base_ff     <= base_in;
      space_ff    <= space_in;
      out_char_ff <= out_char_in;
      out_last_ff <= out_last_in;
      out_bad_ff  <= out_bad_in;
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {1'b0, out_char_ff};
   assign rsp_tlast  = out_last_ff;
   assign rsp_tuser  = out_bad_ff;

endmodule

`default_nettype wire

/* test/radix_number_to_ascii_core_test.sv */
// Self-checking testbench for radix_number_to_ascii_core: directed and random numbers,
// with each character predicted in the bench and checked as it leaves the rsp_ stream.
// Depends on rnta_pkg and the core RTL only.
`timescale 1ns / 100ps

module radix_number_to_ascii_core_test;
   import rnta_pkg::*;

   localparam int CLOCK_PERIOD = 10;
   localparam int RESET_CYCLES = 11;
   localparam int DRAIN_CYCLES = 80;
   localparam int CYCLE_LIMIT  = 1000000;
   localparam int RANDOM_ITEMS = 100;

   typedef struct packed {
      char_type code;
      logic     last;
      logic     bad_base;
   } char_result_type;

   logic        clock;
   logic        reset;
   logic        req_tvalid;
   logic        req_tready;
   logic [39:0] req_tdata;    // opcode [1:0], radix [7:2], value [39:8]
   logic        rsp_tvalid;
   logic        rsp_tready;
   logic [7:0]  rsp_tdata;    // char_code [6:0], zero [7]
   logic        rsp_tlast;
   logic        rsp_tuser;    // bad_base [0]

   char_result_type expected_chars[$];
   int unsigned error_count  = 0;
   int unsigned number_count = 0;
   int unsigned char_count   = 0;
   int unsigned burst_left   = 0;
   int unsigned cycle_count  = 0;

   logic [7:0]  ready_pattern = 8'hff;
   int unsigned pattern_pos   = 0;

   radix_number_to_ascii_core dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata),
      .rsp_tlast  (rsp_tlast),
      .rsp_tuser  (rsp_tuser)
   );

   initial begin
      clock = 1'b0;
      forever #(CLOCK_PERIOD / 2) clock = ~clock;
   end

   initial begin
      while (cycle_count < CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("radix_number_to_ascii_core_test: errors");
      $finish;
   end

   // Work out the characters of one number and queue them in output order.
   function automatic void predict_chars(input opcode_type op, input radix_type rdx,
                                         input value_type val);
      int unsigned     base;
      logic            trailing_space;
      digit_type       digits[$];
      digit_type       d;
      value_type       v;
      char_result_type entry;
      base = 2;
      trailing_space = 1'b0;
      v = val;
      case (op)
         OP_HEX: begin
            base = HEX_RADIX;
            trailing_space = 1'b1;
         end
         OP_OCT: begin
            base = OCT_RADIX;
            trailing_space = 1'b1;
         end
         OP_BIN: begin
            base = BIN_RADIX;
         end
         default: begin
            base = rdx;
            if (rdx < MIN_RADIX) begin
               entry.code = ERROR_CHAR;
               entry.last = 1'b1;
               entry.bad_base = 1'b1;
               expected_chars.push_back(entry);
               return;
            end
            if (rdx > MAX_RADIX) base = MAX_RADIX;
         end
      endcase
      if (v == '0) begin
         digits.push_front('0);
      end else begin
         while (v != '0) begin
            digits.push_front(digit_type'(v % base));
            v = v / base;
         end
      end
      for (int i = 0; i < digits.size(); i++) begin
         d = digits[i];
         entry.code = (d < DECIMAL_LIMIT) ? DIGIT_BASE_CHAR + char_type'(d)
                                          : LETTER_BASE_CHAR + char_type'(d);
         entry.last = (i == digits.size() - 1) && !trailing_space;
         entry.bad_base = 1'b0;
         expected_chars.push_back(entry);
      end
      if (trailing_space) begin
         entry.code = SPACE_CHAR;
         entry.last = 1'b1;
         entry.bad_base = 1'b0;
         expected_chars.push_back(entry);
      end
   endfunction

   // Hold the number on req_ until it transfers; idle between bursts.
   task automatic send_number(input opcode_type op, input radix_type rdx,
                              input value_type val);
      int unsigned gap;
      req_tdata  <= {val, rdx, op};
      req_tvalid <= 1'b1;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
      predict_chars(op, rdx, val);
      number_count++;
      if (burst_left == 0) begin
         burst_left = $urandom_range(0, 5);
         gap = $urandom_range(1, 40);
         req_tvalid <= 1'b0;
         repeat (gap) @(posedge clock);
      end else begin
         burst_left--;
      end
   endtask

   task automatic drain_results();
      req_tvalid <= 1'b0;
      while (expected_chars.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
   endtask

   task automatic test_zero_values();
      send_number(OP_HEX, 6'd0, 32'd0);
      send_number(OP_OCT, 6'd0, 32'd0);
      send_number(OP_BIN, 6'd0, 32'd0);
      send_number(OP_GIVEN, 6'd10, 32'd0);
      send_number(OP_GIVEN, 6'd36, 32'd0);
   endtask

   task automatic test_value_extremes();
      send_number(OP_HEX, 6'd0, 32'hffff_ffff);
      send_number(OP_OCT, 6'd0, 32'hffff_ffff);
      send_number(OP_BIN, 6'd0, 32'hffff_ffff);
      send_number(OP_BIN, 6'd0, 32'd1);
      send_number(OP_GIVEN, 6'd2, 32'hffff_ffff);
      send_number(OP_GIVEN, 6'd36, 32'hffff_ffff);
      send_number(OP_GIVEN, 6'd10, 32'hffff_ffff);
      send_number(OP_HEX, 6'd0, 32'h8000_0000);
   endtask

   // The radix field must be ignored outside given-base mode.
   task automatic test_every_mode();
      send_number(OP_HEX, 6'd63, 32'hdead_beef);
      send_number(OP_OCT, 6'd1, 32'h0012_3456);
      send_number(OP_BIN, 6'd0, 32'h0000_a5c3);
   endtask

   task automatic test_bad_base();
      send_number(OP_GIVEN, 6'd0, $urandom);
      send_number(OP_GIVEN, 6'd1, 32'd0);
      send_number(OP_GIVEN, 6'd1, 32'hffff_ffff);
   endtask

   task automatic test_radix_saturation();
      send_number(OP_GIVEN, 6'd37, 32'hffff_ffff);
      send_number(OP_GIVEN, 6'd63, 32'h1234_5678);
   endtask

   task automatic test_random_numbers(input int unsigned count);
      opcode_type  op;
      radix_type   rdx;
      value_type   val;
      int unsigned pick;
      for (int unsigned n = 0; n < count; n++) begin
         op = opcode_type'($urandom_range(0, 3));
         rdx = radix_type'($urandom_range(0, 63));
         if (op == OP_GIVEN) begin
            pick = $urandom_range(0, 19);
            if (pick == 0) rdx = radix_type'($urandom_range(0, 1));
            else if (pick < 3) rdx = radix_type'($urandom_range(37, 63));
            else rdx = radix_type'($urandom_range(2, 36));
         end
         // Spread magnitudes so short and long digit strings both occur.
         pick = $urandom_range(0, 15);
         if (pick == 0) val = '1;
         else if (pick == 1) val = '0;
         else val = $urandom >> $urandom_range(0, 31);
         send_number(op, rdx, val);
      end
   endtask

   // Receiver: replay an 8-bit ready pattern bit by bit, reloaded each time it runs out.
   always @(posedge clock) begin
      if (pattern_pos == 0) begin
         if ($urandom_range(0, 2) == 0) ready_pattern <= 8'hff;
         else ready_pattern <= 8'($urandom);
      end
      rsp_tready  <= ready_pattern[pattern_pos];
      pattern_pos <= (pattern_pos + 1) % 8;
   end

   always @(posedge clock) begin
      char_result_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         char_count++;
         if (expected_chars.size() == 0) begin
            error_count++;
            $display("%0t: unexpected transfer: tdata %h tlast %b tuser %b",
                     $time, rsp_tdata, rsp_tlast, rsp_tuser);
         end else begin
            want = expected_chars.pop_front();
            if (rsp_tdata !== {1'b0, want.code}) begin
               error_count++;
               $display("%0t: tdata expected %h actual %h", $time, {1'b0, want.code},
                        rsp_tdata);
            end
            if (rsp_tlast !== want.last) begin
               error_count++;
               $display("%0t: tlast expected %b actual %b", $time, want.last, rsp_tlast);
            end
            if (rsp_tuser !== want.bad_base) begin
               error_count++;
               $display("%0t: tuser expected %b actual %b", $time, want.bad_base,
                        rsp_tuser);
            end
         end
      end
   end

   initial begin
      reset      <= 1'b1;
      req_tvalid <= 1'b0;
      req_tdata  <= '0;
      rsp_tready <= 1'b0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_zero_values();
      test_value_extremes();
      test_every_mode();
      test_bad_base();
      test_radix_saturation();
      drain_results();
      test_random_numbers(RANDOM_ITEMS);
      drain_results();

      if (expected_chars.size() != 0) begin
         error_count++;
         $display("%0t: %0d expected characters never arrived", $time,
                  expected_chars.size());
      end
      $display("Converted %0d numbers in hex, octal, binary and bases 0 to 63;", number_count);
      $display("checked %0d characters in %0d cycles.", char_count, cycle_count);
      if (error_count == 0) begin
         $display("radix_number_to_ascii_core_test: clean");
      end else begin
         $display("radix_number_to_ascii_core_test: errors");
      end
      $finish;
   end

endmodule
